// File: sv/ldart_pkg.sv
// Package for the lane delivery tracker: constants, request codes and result type.
package ldart_pkg;

  // Default number of scanner lanes
  localparam int unsigned LANES_DEFAULT = 2;

  // Retry interval after reset, in milliseconds
  localparam logic [15:0] RETRY_INTERVAL_RESET = 16'd1000;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_OBSERVE = 2'd0,
    REQ_SENT    = 2'd1,
    REQ_CHECK   = 2'd2
  } req_e;

  // One result item
  typedef struct packed {
    logic boot_changed;
    logic retry_due;
    logic unsent_found;
    logic next_unsent_lane;
    logic all_sent;
    logic ack_waiting;
  } result_t;

endpackage

// File: sv/lane_delivery_ack_retry_tracker_unit.sv
// Top level of the lane delivery and acknowledgment retry tracker.
//
// Input channel: in_valid_i with req_type_i, lane_i, boot_id_i, now_ms_i and
// ack_matches_i; an item is taken on a clock edge where in_valid_i is high and
// in_stall_o is low. Each item updates the per-lane boot identifiers, sent
// marks and the acknowledgment deadline.
// Output channel: out_valid_o with the six status fields; the receiver holds
// out_stall_i high to keep an item in place.
// Timing: the result of an item is registered and shown on out_valid_o in the
// cycle after it is accepted when the output is not stalled. Throughput: one
// item per cycle unless stalled, set by the core and the result register.
// Stall: a skid stage behind the result register takes one more item while
// the output is stalled; in_stall_o rises only once both are occupied.
// Configuration: cfg_we_i writes cfg_wdata_i into the retry interval; write it
// only while no item is in flight.
// Reset: rst_ni clears all identifiers, marks, the deadline and both output
// stages, and sets the retry interval to 1000 ms.
module lane_delivery_ack_retry_tracker_unit #(
  parameter int unsigned LANES = ldart_pkg::LANES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic        lane_i,
  input  logic [31:0] boot_id_i,
  input  logic [31:0] now_ms_i,
  input  logic        ack_matches_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        boot_changed_o,
  output logic        retry_due_o,
  output logic        unsent_found_o,
  output logic        next_unsent_lane_o,
  output logic        all_sent_o,
  output logic        ack_waiting_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic               accept;
  logic               full;
  ldart_pkg::result_t result;
  ldart_pkg::result_t out_data;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  ldart_core #(
    .LANES (LANES)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .lane_i        (lane_i),
    .boot_id_i     (boot_id_i),
    .now_ms_i      (now_ms_i),
    .ack_matches_i (ack_matches_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_o      (result)
  );

  ldart_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_data)
  );

  assign boot_changed_o     = out_data.boot_changed;
  assign retry_due_o        = out_data.retry_due;
  assign unsent_found_o     = out_data.unsent_found;
  assign next_unsent_lane_o = out_data.next_unsent_lane;
  assign all_sent_o         = out_data.all_sent;
  assign ack_waiting_o      = out_data.ack_waiting;

endmodule

// File: sv/ldart_core.sv
// Tracker state and single-pass event update producing one result per item.
module ldart_core #(
  parameter int unsigned LANES = ldart_pkg::LANES_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          req_type_i,
  input  logic                lane_i,
  input  logic [31:0]         boot_id_i,
  input  logic [31:0]         now_ms_i,
  input  logic                ack_matches_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  output ldart_pkg::result_t  result_o
);

  logic [LANES-1:0][31:0] boot_ids_q, boot_ids_d;
  logic [LANES-1:0]       marks_q, marks_d;
  logic                   waiting_q, waiting_d;
  logic [31:0]            deadline_q, deadline_d;
  logic [15:0]            interval_q;

  logic [LANES-1:0]       lane_oh;
  logic [31:0]            old_id;
  logic [LANES-1:0]       marks_set;
  logic [31:0]            elapsed;
  logic                   changed;
  logic                   due;
  logic                   found;
  logic                   next_lane;

  // Decode the lane; a lane beyond the last one decodes to no lane at all
  assign lane_oh = LANES'(1) << lane_i;
  assign marks_set = marks_q | lane_oh;
  assign elapsed = now_ms_i - deadline_q;

  // Pick the stored identifier of the addressed lane
  always_comb begin
    old_id = '0;
    for (int unsigned i = 0; i < LANES; i++) begin
      if (lane_oh[i]) begin
        old_id = old_id | boot_ids_q[i];
      end
    end
  end

  // Work out the next state for this item
  always_comb begin
    boot_ids_d = boot_ids_q;
    marks_d    = marks_q;
    waiting_d  = waiting_q;
    deadline_d = deadline_q;
    changed    = 1'b0;
    due        = 1'b0;
    unique case (ldart_pkg::req_e'(req_type_i))
      ldart_pkg::REQ_OBSERVE: begin
        if ((|lane_oh) && (boot_id_i != '0) && (old_id != boot_id_i)) begin
          for (int unsigned i = 0; i < LANES; i++) begin
            if (lane_oh[i]) begin
              boot_ids_d[i] = boot_id_i;
            end
          end
          marks_d    = '0;
          waiting_d  = 1'b0;
          deadline_d = '0;
          changed    = 1'b1;
        end
      end
      ldart_pkg::REQ_SENT: begin
        if (|lane_oh) begin
          marks_d = marks_set;
          // Arm the deadline once every lane has the announcement
          if ((&marks_set) && !waiting_q) begin
            deadline_d = now_ms_i + {16'd0, interval_q};
            waiting_d  = 1'b1;
          end
        end
      end
      ldart_pkg::REQ_CHECK: begin
        if (ack_matches_i) begin
          deadline_d = '0;
          waiting_d  = 1'b0;
        end else if (waiting_q && (&marks_q) && !elapsed[31]) begin
          // Deadline passed: flag retry and drop delivery
          marks_d    = '0;
          waiting_d  = 1'b0;
          deadline_d = '0;
          due        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Find the lowest unsent lane after the update
  always_comb begin
    found     = 1'b0;
    next_lane = 1'b0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (!marks_d[i]) begin
        found     = 1'b1;
        next_lane = i[0];
      end
    end
  end

  always_comb begin
    result_o.boot_changed     = changed;
    result_o.retry_due        = due;
    result_o.unsent_found     = found;
    result_o.next_unsent_lane = next_lane;
    result_o.all_sent         = &marks_d;
    result_o.ack_waiting      = waiting_d;
  end

  // Advance state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_ids_q <= '0;
      marks_q    <= '0;
      waiting_q  <= 1'b0;
      deadline_q <= '0;
    end else if (accept_i) begin
      boot_ids_q <= boot_ids_d;
      marks_q    <= marks_d;
      waiting_q  <= waiting_d;
      deadline_q <= deadline_d;
    end
  end

  // Hold the retry interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= ldart_pkg::RETRY_INTERVAL_RESET;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

endmodule

// File: sv/ldart_outbuf.sv
// Result register with a skid stage so input can take one more item while output stalls.
module ldart_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ldart_pkg::result_t  data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ldart_pkg::result_t  data_o
);

  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  ldart_pkg::result_t out_q, out_d;
  ldart_pkg::result_t skid_q, skid_d;
  logic               take;

  assign take = out_valid_q && !out_stall_i;

  // Move items between the result register and the skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;

endmodule

// File: verif/lane_delivery_ack_retry_tracker_unit_test.sv
// Self-checking testbench for the lane delivery and acknowledgment retry tracker.
module lane_delivery_ack_retry_tracker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the block must treat as a no-op
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned NUM_LANES = ldart_pkg::LANES_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 85;

  typedef struct packed {
    logic [1:0]  req;
    logic        lane;
    logic [31:0] boot_id;
    logic [31:0] now_ms;
    logic        ack;
  } event_t;

  // Block ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic        lane_i = 1'b0;
  logic [31:0] boot_id_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        ack_matches_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        boot_changed_o;
  logic        retry_due_o;
  logic        unsent_found_o;
  logic        next_unsent_lane_o;
  logic        all_sent_o;
  logic        ack_waiting_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  // Predicted tracker state
  logic [31:0]          lane_ids [NUM_LANES];
  logic [NUM_LANES-1:0] sent_marks = '0;
  logic                 ack_wait = 1'b0;
  logic [31:0]          deadline_ms = '0;
  logic [15:0]          retry_ms = ldart_pkg::RETRY_INTERVAL_RESET;

  // Stimulus and checking bookkeeping
  event_t             pending_events [$];
  ldart_pkg::result_t expected_status [$];
  event_t             drv_ev;
  event_t             mon_ev;
  ldart_pkg::result_t exp_status;
  logic [31:0]        gen_ids [2];
  logic [15:0]        gen_interval = ldart_pkg::RETRY_INTERVAL_RESET;
  logic               in_taken = 1'b0;
  logic               out_taken = 1'b0;
  int                 in_gap = 0;
  int                 out_wait = 0;
  int                 in_gap_max = 10;
  int                 out_gap_max = 10;
  int                 item_count = 0;
  int                 errors = 0;
  int                 cycle_count = 0;

  lane_delivery_ack_retry_tracker_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .lane_i             (lane_i),
    .boot_id_i          (boot_id_i),
    .now_ms_i           (now_ms_i),
    .ack_matches_i      (ack_matches_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .boot_changed_o     (boot_changed_o),
    .retry_due_o        (retry_due_o),
    .unsent_found_o     (unsent_found_o),
    .next_unsent_lane_o (next_unsent_lane_o),
    .all_sent_o         (all_sent_o),
    .ack_waiting_o      (ack_waiting_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // Clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < NUM_LANES; i++) lane_ids[i] = '0;
    gen_ids[0] = '0;
    gen_ids[1] = '0;
  end

  // Apply one event to the predicted state and return the status it reports
  function automatic ldart_pkg::result_t track_event(event_t ev);
    ldart_pkg::result_t res;
    logic [31:0]        elapsed;
    int                 i;
    res = '0;
    elapsed = ev.now_ms - deadline_ms;
    case (ev.req)
      ldart_pkg::REQ_OBSERVE: begin
        if (ev.lane < NUM_LANES && ev.boot_id != '0 && lane_ids[ev.lane] != ev.boot_id) begin
          lane_ids[ev.lane] = ev.boot_id;
          sent_marks = '0;
          deadline_ms = '0;
          ack_wait = 1'b0;
          res.boot_changed = 1'b1;
        end
      end
      ldart_pkg::REQ_SENT: begin
        if (ev.lane < NUM_LANES) begin
          sent_marks[ev.lane] = 1'b1;
          if (&sent_marks && !ack_wait) begin
            deadline_ms = ev.now_ms + {16'd0, retry_ms};
            ack_wait = 1'b1;
          end
        end
      end
      ldart_pkg::REQ_CHECK: begin
        if (ev.ack) begin
          deadline_ms = '0;
          ack_wait = 1'b0;
        end else if (ack_wait && &sent_marks && !elapsed[31]) begin
          sent_marks = '0;
          deadline_ms = '0;
          ack_wait = 1'b0;
          res.retry_due = 1'b1;
        end
      end
      default: ;
    endcase
    // Report the lowest lane still unsent
    for (i = 0; i < NUM_LANES; i++) begin
      if (!sent_marks[i] && !res.unsent_found) begin
        res.unsent_found = 1'b1;
        res.next_unsent_lane = i[0];
      end
    end
    res.all_sent = &sent_marks;
    res.ack_waiting = ack_wait;
    return res;
  endfunction

  task automatic check_field(string name, logic expv, logic actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch: expected %0b actual %0b", $time, name, expv, actv);
      errors++;
    end
  endtask

  task automatic push_event(logic [1:0] req, logic lane, logic [31:0] id, logic [31:0] now,
                            logic ack);
    event_t ev;
    ev.req = req;
    ev.lane = lane;
    ev.boot_id = id;
    ev.now_ms = now;
    ev.ack = ack;
    pending_events.push_back(ev);
    item_count++;
  endtask

  // Driver: present items at the falling edge, hold them while stalled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (pending_events.size() != 0) begin
          drv_ev = pending_events.pop_front();
          req_type_i <= drv_ev.req;
          lane_i <= drv_ev.lane;
          boot_id_i <= drv_ev.boot_id;
          now_ms_i <= drv_ev.now_ms;
          ack_matches_i <= drv_ev.ack;
          in_valid_i <= 1'b1;
          in_gap = $urandom_range(0, in_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // Draw a fresh receiver stall for each result taken
      if (out_taken) out_wait = $urandom_range(0, out_gap_max);
      if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: check results and predict accepted items at the rising edge
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    if (out_taken) begin
      if (expected_status.size() == 0) begin
        $display("%0t: result with no item pending: expected none actual %b%b%b%b%b%b",
                 $time, boot_changed_o, retry_due_o, unsent_found_o, next_unsent_lane_o,
                 all_sent_o, ack_waiting_o);
        errors++;
      end else begin
        exp_status = expected_status.pop_front();
        check_field("boot_changed", exp_status.boot_changed, boot_changed_o);
        check_field("retry_due", exp_status.retry_due, retry_due_o);
        check_field("unsent_found", exp_status.unsent_found, unsent_found_o);
        check_field("next_unsent_lane", exp_status.next_unsent_lane, next_unsent_lane_o);
        check_field("all_sent", exp_status.all_sent, all_sent_o);
        check_field("ack_waiting", exp_status.ack_waiting, ack_waiting_o);
      end
    end
    if (in_taken) begin
      mon_ev.req = req_type_i;
      mon_ev.lane = lane_i;
      mon_ev.boot_id = boot_id_i;
      mon_ev.now_ms = now_ms_i;
      mon_ev.ack = ack_matches_i;
      expected_status.push_back(track_event(mon_ev));
    end
  end

  // Hold until every item has gone through and its result has been checked
  task automatic wait_idle();
    while (pending_events.size() != 0 || in_valid_i || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    retry_ms = value;
    gen_interval = value;
  endtask

  // One delivery round: maybe a new identifier, both lanes sent, checks near the deadline
  task automatic add_round();
    logic [31:0] base;
    logic [31:0] arm;
    logic [31:0] id;
    logic        first;
    int          n;
    int          k;
    int          off;
    base = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      first = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: id = '0;
        1: id = gen_ids[first];
        default: id = $urandom;
      endcase
      if (id != '0) gen_ids[first] = id;
      push_event(ldart_pkg::REQ_OBSERVE, first, id, base, 1'($urandom_range(0, 1)));
    end
    first = 1'($urandom_range(0, 1));
    push_event(ldart_pkg::REQ_SENT, first, $urandom, base, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      push_event(ldart_pkg::REQ_SENT, first, $urandom, base + 1, 1'($urandom_range(0, 1)));
    arm = base + $urandom_range(0, 50);
    push_event(ldart_pkg::REQ_SENT, !first, $urandom, arm, 1'($urandom_range(0, 1)));
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      off = $urandom_range(0, 6) - 3;
      push_event(ldart_pkg::REQ_CHECK, 1'($urandom_range(0, 1)), $urandom,
                 ($urandom_range(0, 7) == 0) ? $urandom : arm + {16'd0, gen_interval} + off,
                 $urandom_range(0, 5) == 0);
    end
  endtask

  // Directed items at the reset interval of 1000 ms
  task automatic load_directed();
    push_event(ldart_pkg::REQ_CHECK, 1'b0, 32'h0, 32'h0, 1'b0);
    push_event(ldart_pkg::REQ_CHECK, 1'b1, 32'h0, 32'h0, 1'b1);
    push_event(ldart_pkg::REQ_OBSERVE, 1'b0, 32'h0, 32'h0, 1'b0);
    push_event(ldart_pkg::REQ_OBSERVE, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    push_event(ldart_pkg::REQ_OBSERVE, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    push_event(ldart_pkg::REQ_OBSERVE, 1'b1, 32'h1, 32'hFFFF_FFFF, 1'b1);
    push_event(ldart_pkg::REQ_SENT, 1'b1, 32'h0, 32'h0, 1'b0);
    push_event(ldart_pkg::REQ_SENT, 1'b1, 32'h0, 32'h0, 1'b0);
    // Deadline wraps past zero
    push_event(ldart_pkg::REQ_SENT, 1'b0, 32'h0, 32'hFFFF_FF00, 1'b0);
    // Sent while waiting: no re-arm
    push_event(ldart_pkg::REQ_SENT, 1'b0, 32'h0, 32'h0, 1'b0);
    push_event(ldart_pkg::REQ_CHECK, 1'b0, 32'h0, 32'h0000_02E7, 1'b0);
    push_event(ldart_pkg::REQ_CHECK, 1'b0, 32'h0, 32'h0000_02E8, 1'b0);
    push_event(ldart_pkg::REQ_CHECK, 1'b0, 32'h0, 32'h0000_02E8, 1'b0);
    push_event(ldart_pkg::REQ_SENT, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_event(ldart_pkg::REQ_SENT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // Ack clears the wait but keeps the marks
    push_event(ldart_pkg::REQ_CHECK, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b1);
    push_event(ldart_pkg::REQ_CHECK, 1'b0, 32'h0, 32'h0000_03E7, 1'b0);
    // All sent and not waiting: a further sent re-arms
    push_event(ldart_pkg::REQ_SENT, 1'b1, 32'h0, 32'h0, 1'b0);
    push_event(ldart_pkg::REQ_CHECK, 1'b0, 32'h0, 32'd1000 + 32'h8000_0000, 1'b0);
    push_event(ldart_pkg::REQ_CHECK, 1'b0, 32'h0, 32'd1000 + 32'h7FFF_FFFF, 1'b0);
    push_event(REQ_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_event(ldart_pkg::REQ_SENT, 1'b0, 32'h0, 32'h5, 1'b0);
    push_event(ldart_pkg::REQ_SENT, 1'b1, 32'h0, 32'h5, 1'b0);
    // New identifier while waiting drops the delivery
    push_event(ldart_pkg::REQ_OBSERVE, 1'b1, 32'h2, 32'h5, 1'b0);
    push_event(ldart_pkg::REQ_CHECK, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    gen_ids[0] = 32'hFFFF_FFFF;
    gen_ids[1] = 32'h2;
  endtask

  // Timeout guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence: reset, directed items, then random phases per interval
  initial begin
    logic [15:0] intervals [6];
    int          p;
    int          target;
    intervals[0] = 16'd0;
    intervals[1] = 16'hFFFF;
    intervals[2] = 16'd1;
    intervals[3] = 16'($urandom);
    intervals[4] = ldart_pkg::RETRY_INTERVAL_RESET;
    intervals[5] = 16'($urandom);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    load_directed();
    wait_idle();
    for (p = 0; p < 6; p++) begin
      write_interval(intervals[p]);
      in_gap_max = (p == 1 || p == 3) ? 0 : 10;
      out_gap_max = (p == 2 || p == 3) ? 0 : 10;
      target = item_count + PHASE_ITEMS;
      while (item_count < target) begin
        if ($urandom_range(0, 4) == 0)
          push_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom, $urandom,
                     1'($urandom_range(0, 1)));
        else
          add_round();
      end
      wait_idle();
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: lane_delivery_ack_retry_tracker_unit.f
sv/ldart_pkg.sv
sv/ldart_core.sv
sv/ldart_outbuf.sv
sv/lane_delivery_ack_retry_tracker_unit.sv
verif/lane_delivery_ack_retry_tracker_unit_test.sv
